// File: hdl/mbps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared constants, register codes and types of the masked byte pattern scan.
// ----------------------------------------------------------------------------
package mbps_pkg;

    localparam int MAX_PATTERN_BYTES = 32;
    localparam int OFFSET_BITS       = 32;
    localparam int PATTERN_REGS      = 4;
    localparam int STORED_BYTES      = PATTERN_REGS * 8;
    localparam int LEN_BITS          = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int SHIFT_BITS        = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
    localparam int MATCH_OFFSET_BITS = 32;

    // configuration port
    localparam int APB_ADDR_BITS = 6;
    localparam int APB_DATA_BITS = 64;
    localparam int REG_IDX_BITS  = 3;

    localparam logic [REG_IDX_BITS-1:0] REG_PATTERN_0_7   = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_PATTERN_8_15  = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_PATTERN_16_23 = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_PATTERN_24_31 = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_CARE_MASK     = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_PATTERN_LEN   = 3'd5;

    typedef logic [MAX_PATTERN_BYTES-1:0][7:0] t_window;

    // pattern setup as the matcher sees it; len is already clamped to 1..max
    typedef struct packed {
        logic [STORED_BYTES-1:0][7:0] pattern;
        logic [STORED_BYTES-1:0]      care;
        logic [LEN_BITS-1:0]          len;
    } t_cfg;

endpackage

// File: hdl/mbps_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_cfg
// APB register file holding the pattern, care mask and pattern length.
// ----------------------------------------------------------------------------
module mbps_cfg
    import mbps_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output t_cfg                     o_cfg
);

    logic [PATTERN_REGS-1:0][63:0] r_pattern;
    logic [31:0]                   r_care;
    logic [5:0]                    r_len;
    logic [REG_IDX_BITS-1:0]       reg_idx;
    logic                          wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_BITS-1:3];
    assign wr_en   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_care    <= '0;
            r_len     <= 6'd1;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_PATTERN_0_7:   r_pattern[0] <= pwdata;
                REG_PATTERN_8_15:  r_pattern[1] <= pwdata;
                REG_PATTERN_16_23: r_pattern[2] <= pwdata;
                REG_PATTERN_24_31: r_pattern[3] <= pwdata;
                REG_CARE_MASK:     r_care       <= pwdata[31:0];
                REG_PATTERN_LEN:   r_len        <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PATTERN_0_7:   prdata = r_pattern[0];
            REG_PATTERN_8_15:  prdata = r_pattern[1];
            REG_PATTERN_16_23: prdata = r_pattern[2];
            REG_PATTERN_24_31: prdata = r_pattern[3];
            REG_CARE_MASK:     prdata = {32'd0, r_care};
            REG_PATTERN_LEN:   prdata = {58'd0, r_len};
            default:           prdata = '0;
        endcase
    end

    // zero acts as one, anything above the window size as the window size
    always_comb begin
        o_cfg.pattern = r_pattern;
        o_cfg.care    = r_care;
        if (r_len == 6'd0) begin
            o_cfg.len = LEN_BITS'(1);
        end else if ({1'b0, r_len} > 7'(MAX_PATTERN_BYTES)) begin
            o_cfg.len = LEN_BITS'(MAX_PATTERN_BYTES);
        end else begin
            o_cfg.len = LEN_BITS'(r_len);
        end
    end

endmodule

// File: hdl/mbps_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_match
// Parallel masked byte comparators between the byte window and the pattern.
// ----------------------------------------------------------------------------
module mbps_match
    import mbps_pkg::*;
(
    input  t_cfg    i_cfg,
    input  t_window i_window,
    output logic    o_fit
);

    logic [MAX_PATTERN_BYTES-1:0][7:0] rev_pat;
    logic [MAX_PATTERN_BYTES-1:0]      rev_care;
    logic [MAX_PATTERN_BYTES-1:0][7:0] pat_s;
    logic [MAX_PATTERN_BYTES-1:0]      care_s;
    logic [SHIFT_BITS-1:0]             shift;
    logic [MAX_PATTERN_BYTES-1:0]      fit;

    // reverse so the newest window byte lines up with the last pattern byte
    always_comb begin
        for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
            if (MAX_PATTERN_BYTES - 1 - k < STORED_BYTES) begin
                rev_pat[k]  = i_cfg.pattern[MAX_PATTERN_BYTES - 1 - k];
                rev_care[k] = i_cfg.care[MAX_PATTERN_BYTES - 1 - k];
            end else begin
                rev_pat[k]  = 8'd0;
                rev_care[k] = 1'b0;
            end
        end
    end

    assign shift  = SHIFT_BITS'(LEN_BITS'(MAX_PATTERN_BYTES) - i_cfg.len);
    assign pat_s  = rev_pat >> {shift, 3'b000};
    assign care_s = rev_care >> shift;

    always_comb begin
        for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
            fit[j] = (LEN_BITS'(j) >= i_cfg.len) | ~care_s[j] | (pat_s[j] == i_window[j]);
        end
    end

    assign o_fit = &fit;

endmodule

// File: hdl/masked_byte_pattern_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_byte_pattern_scan
// Finds the first wildcard pattern match in a byte stream region.
//
//   channel | direction | handshake                  | word
//   --------+-----------+----------------------------+---------------------------------
//   input   | in        | i_in_valid / o_in_stall    | data_byte, region_start/end
//   output  | out       | o_out_valid / i_out_stall  | found, match_offset
//   config  | in        | APB psel/penable/pready    | 64-bit registers at 8*index
//
// one word per cycle sustained while the output is not stalled; each accepted
// word passes the input register, then the compare into the result register
// synchronous active-low reset clears the scan state and the register file
// an output stall holds the result; the input register keeps taking one
// more word and then stalls the input side
// ----------------------------------------------------------------------------
module masked_byte_pattern_scan
    import mbps_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [7:0]                   i_data_byte,
    input  logic                         i_region_start,
    input  logic                         i_region_end,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_found,
    output logic [MATCH_OFFSET_BITS-1:0] o_match_offset,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [APB_ADDR_BITS-1:0]     paddr,
    input  logic [APB_DATA_BITS-1:0]     pwdata,
    output logic [APB_DATA_BITS-1:0]     prdata,
    output logic                         pready
);

    t_cfg cfg;

    logic                   r_in_valid, n_in_valid;
    logic [7:0]             r_in_data;
    logic                   r_in_start;
    logic                   r_in_end;

    t_window                r_window, n_window;
    logic [OFFSET_BITS-1:0] r_count, count_base, n_count;
    logic                   r_done;

    logic                   r_out_valid, n_out_valid;
    logic                   r_found;
    logic [MATCH_OFFSET_BITS-1:0] r_offset;

    logic                   out_block, fire, in_accept;
    logic                   eff_done, fit, hit, has_result;
    logic [OFFSET_BITS-1:0] diff;

    mbps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign out_block  = r_out_valid & i_out_stall;
    assign fire       = r_in_valid & ~out_block;
    assign o_in_stall = r_in_valid & out_block;
    assign in_accept  = i_in_valid & ~o_in_stall;
    assign n_in_valid = in_accept | (r_in_valid & ~fire);

    // only window entries below the count are ever compared, so a region
    // start needs to clear the count alone
    assign eff_done   = ~r_in_start & r_done;
    assign count_base = r_in_start ? '0 : r_count;
    assign n_count    = (&count_base) ? count_base : count_base + 1'b1;
    assign n_window   = {r_window[MAX_PATTERN_BYTES-2:0], r_in_data};

    mbps_match u_match (
        .i_cfg    (cfg),
        .i_window (n_window),
        .o_fit    (fit)
    );

    assign hit        = fit & (n_count >= OFFSET_BITS'(cfg.len));
    assign has_result = ~eff_done & (hit | r_in_end);
    assign diff       = n_count - OFFSET_BITS'(cfg.len);

    always_comb begin
        if (fire & has_result) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_done      <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (fire & ~eff_done) begin
                r_count <= n_count;
                r_done  <= has_result;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_data  <= i_data_byte;
            r_in_start <= i_region_start;
            r_in_end   <= i_region_end;
        end
        if (fire & ~eff_done) begin
            r_window <= n_window;
        end
        if (fire & has_result) begin
            r_found  <= hit;
            r_offset <= hit ? diff[MATCH_OFFSET_BITS-1:0] : '0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_found;
    assign o_match_offset = r_offset;

endmodule
